[rtl/assert_macros.svh]
// assertion macros shared by the box filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define BXF_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bxf assertion failed");

`define BXF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bxf assertion failed");

`else

`define BXF_ASSERT(lbl, clk, rst_n, prop)
`define BXF_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[rtl/bxf_pkg.sv]
// types, constants and helpers of the 3x3 box filter
`default_nettype none

package bxf_pkg;

    localparam int PIXEL_BITS     = 8;
    localparam int CFG_BITS       = 11;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_BITS-1:0] RESET_SIZE = 11'd400;

    localparam int HEIGHT_LIMIT = 1024;
    localparam int ROW_BITS     = $clog2(HEIGHT_LIMIT);

    // one column of three pixels, and a full window of nine
    localparam int COLSUM_BITS = 10;
    localparam int SUM_BITS    = 12;

    // floor(x / 9) == (x * 1821) >> 14 for every x below 3276
    localparam int DIV9_RECIP = 1821;
    localparam int DIV9_SHIFT = 14;
    localparam int PROD_BITS  = SUM_BITS + 11;

    localparam int QUEUE_DEPTH     = 8;
    localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_out;
        logic                  last_of_run;
        logic                  row_end;
        logic                  frame_end;
    } result_t;

    typedef struct packed {
        logic [SUM_BITS-1:0] sum;
        logic                last_of_run;
        logic                row_end;
        logic                frame_end;
    } sum_res_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic logic [PIXEL_BITS-1:0] div9(input logic [SUM_BITS-1:0] sum);
        logic [PROD_BITS-1:0] prod;
        prod = PROD_BITS'(sum) * PROD_BITS'(DIV9_RECIP);
        return prod[DIV9_SHIFT +: PIXEL_BITS];
    endfunction

endpackage

`default_nettype wire

[rtl/bxf_req_if.sv]
// input channel of the box filter: pixel or drain request
`default_nettype none

interface bxf_req_if;
    logic                            valid;
    logic                            ready;
    logic                            req_type;
    logic [bxf_pkg::PIXEL_BITS-1:0]  pixel_in;

    modport source (output valid, output req_type, output pixel_in, input ready);
    modport sink (input valid, input req_type, input pixel_in, output ready);
endinterface

`default_nettype wire

[rtl/bxf_rsp_if.sv]
// output channel of the box filter: filtered pixel and markers
`default_nettype none

interface bxf_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [bxf_pkg::PIXEL_BITS-1:0]  pixel_out;
    logic                            last_of_run;
    logic                            row_end;
    logic                            frame_end;

    modport source (output valid, output pixel_out, output last_of_run,
                    output row_end, output frame_end, input ready);
    modport sink (input valid, input pixel_out, input last_of_run,
                  input row_end, input frame_end, output ready);
endinterface

`default_nettype wire

[rtl/box_filter_3x3_reflect_core.sv]
// top level of the 3x3 reflected box filter
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    req_type, pixel_in
//  rsp      out  valid/ready    pixel_out, last_of_run, row_end, frame_end
//  cfg      in   cfg_write      cfg_index, cfg_data
//
// one item per cycle while req.ready is high; a pixel reads both line stores
// at its column, the read returns in the next cycle and is written back in
// that same stage; results pass the divide stage and the result queue; a
// row end gives two results, so the output side sets the pace at one result
// per cycle while rsp.ready is high; reset clears counters and control
// only; line stores need no clearing pass; req.ready drops while the result
// queue cannot hold two results for every item in flight

`default_nettype none

`include "assert_macros.svh"

module box_filter_3x3_reflect_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [bxf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [bxf_pkg::CFG_BITS-1:0]        cfg_data,
    bxf_req_if.sink                                  req,
    bxf_rsp_if.source                                rsp
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CW  = (AW + 1 > bxf_pkg::CFG_BITS) ? AW + 1 : bxf_pkg::CFG_BITS;
    localparam int RB  = bxf_pkg::ROW_BITS;
    localparam int PB  = bxf_pkg::PIXEL_BITS;
    localparam int CSB = bxf_pkg::COLSUM_BITS;
    localparam int SB  = bxf_pkg::SUM_BITS;
    localparam int QPB = bxf_pkg::QUEUE_PTR_BITS;
    localparam int LW  = QPB + 2;

    // configuration and frame position
    logic [bxf_pkg::CFG_BITS-1:0] image_width_reg;
    logic [bxf_pkg::CFG_BITS-1:0] image_width_next;
    logic [bxf_pkg::CFG_BITS-1:0] image_height_reg;
    logic [bxf_pkg::CFG_BITS-1:0] image_height_next;
    logic [AW-1:0]                col_reg;
    logic [AW-1:0]                col_next;
    logic [RB-1:0]                row_reg;
    logic [RB-1:0]                row_next;
    logic [AW-1:0]                drain_reg;
    logic [AW-1:0]                drain_next;
    logic                         draining_reg;
    logic                         draining_next;
    logic                         restart;

    logic [CW-1:0] width_ext;
    logic [AW-1:0] wlast;
    logic [RB-1:0] hlast;

    logic          acc;
    logic          pix_go;
    logic          drn_go;
    logic          mem_re;
    logic [AW-1:0] rd_addr;
    logic [LW-1:0] need;
    logic [QPB:0]  q_level;

    // read/modify/write stage
    logic          s1_valid_reg;
    logic          s1_drain_reg;
    logic [PB-1:0] s1_pix_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          s1_first_reg;
    logic          s1_second_reg;
    logic          s1_last_reg;
    logic          s1_row0_reg;
    logic          s1_row1_reg;

    logic          older_we;
    logic          newer_we;
    logic [PB-1:0] older_q;
    logic [PB-1:0] newer_q;
    logic          older_fwd_reg;
    logic [PB-1:0] older_fwd_data_reg;
    logic          newer_fwd_reg;
    logic [PB-1:0] newer_fwd_data_reg;
    logic [PB-1:0] older_rd;
    logic [PB-1:0] newer_rd;

    logic [PB-1:0]  top_px;
    logic [CSB-1:0] cs_pix;
    logic [CSB-1:0] cs_drn;
    logic [CSB-1:0] cs_first;
    logic [CSB-1:0] left_cs;
    logic [CSB-1:0] right_cs;
    logic [CSB-1:0] win_left_reg;
    logic [CSB-1:0] win_left_next;
    logic [CSB-1:0] win_mid_reg;
    logic [CSB-1:0] win_mid_next;
    logic [CSB-1:0] cs0_reg;
    logic [CSB-1:0] cs0_next;

    // divide stage
    logic [1:0]          s2_n_reg;
    logic [1:0]          s2_n_next;
    bxf_pkg::sum_res_t   s2_res0_reg;
    bxf_pkg::sum_res_t   s2_res0_next;
    bxf_pkg::sum_res_t   s2_res1_reg;
    bxf_pkg::sum_res_t   s2_res1_next;
    bxf_pkg::push_t      push;

    // effective frame size
    always_comb
    begin
        width_ext = CW'(image_width_reg);
        if (width_ext < CW'(2))
        begin
            wlast = AW'(1);
        end
        else if (width_ext > CW'(MAX_WIDTH))
        begin
            wlast = AW'(MAX_WIDTH - 1);
        end
        else
        begin
            wlast = AW'(width_ext - CW'(1));
        end

        if (image_height_reg < bxf_pkg::CFG_BITS'(2))
        begin
            hlast = RB'(1);
        end
        else if (image_height_reg > bxf_pkg::CFG_BITS'(bxf_pkg::HEIGHT_LIMIT))
        begin
            hlast = RB'(bxf_pkg::HEIGHT_LIMIT - 1);
        end
        else
        begin
            hlast = RB'(image_height_reg - bxf_pkg::CFG_BITS'(1));
        end
    end

    assign need = LW'(q_level) + (s1_valid_reg ? LW'(2) : LW'(0))
                + LW'(s2_n_reg) + LW'(2);
    assign req.ready = (need <= LW'(bxf_pkg::QUEUE_DEPTH));

    assign acc     = req.valid && req.ready;
    assign pix_go  = acc && !req.req_type && !draining_reg;
    assign drn_go  = acc && req.req_type && draining_reg;
    assign mem_re  = pix_go || drn_go;
    assign rd_addr = pix_go ? col_reg : AW'(drain_reg + AW'(1));

    // frame position and configuration
    always_comb
    begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        col_next          = col_reg;
        row_next          = row_reg;
        drain_next        = drain_reg;
        draining_next     = draining_reg;
        restart           = 1'b0;

        if (cfg_write)
        begin
            case (cfg_index)
                bxf_pkg::REG_IMAGE_WIDTH:
                begin
                    image_width_next = cfg_data;
                    restart          = 1'b1;
                end
                bxf_pkg::REG_IMAGE_HEIGHT:
                begin
                    image_height_next = cfg_data;
                    restart           = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end

        if (restart)
        begin
            col_next      = '0;
            row_next      = '0;
            drain_next    = '0;
            draining_next = 1'b0;
        end
        else if (pix_go)
        begin
            if (col_reg == wlast)
            begin
                col_next = '0;
                if (row_reg == hlast)
                begin
                    row_next      = '0;
                    draining_next = 1'b1;
                end
                else
                begin
                    row_next = row_reg + RB'(1);
                end
            end
            else
            begin
                col_next = col_reg + AW'(1);
            end
        end
        else if (drn_go)
        begin
            if (drain_reg == wlast)
            begin
                drain_next    = '0;
                draining_next = 1'b0;
            end
            else
            begin
                drain_next = drain_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= bxf_pkg::RESET_SIZE;
            image_height_reg <= bxf_pkg::RESET_SIZE;
            col_reg          <= '0;
            row_reg          <= '0;
            drain_reg        <= '0;
            draining_reg     <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_n_reg         <= 2'd0;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            drain_reg        <= drain_next;
            draining_reg     <= draining_next;
            s1_valid_reg     <= mem_re;
            s2_n_reg         <= s2_n_next;
        end
    end

    // line stores
    assign older_we = s1_valid_reg && !s1_drain_reg && !s1_row0_reg;
    assign newer_we = s1_valid_reg && !s1_drain_reg;

    bxf_ram #(
        .WIDTH (PB),
        .DEPTH (MAX_WIDTH)
    ) u_older_ram (
        .clk   (clk),
        .we    (older_we),
        .waddr (s1_addr_reg),
        .wdata (newer_rd),
        .re    (mem_re),
        .raddr (rd_addr),
        .rdata (older_q)
    );

    bxf_ram #(
        .WIDTH (PB),
        .DEPTH (MAX_WIDTH)
    ) u_newer_ram (
        .clk   (clk),
        .we    (newer_we),
        .waddr (s1_addr_reg),
        .wdata (s1_pix_reg),
        .re    (mem_re),
        .raddr (rd_addr),
        .rdata (newer_q)
    );

    assign older_rd = older_fwd_reg ? older_fwd_data_reg : older_q;
    assign newer_rd = newer_fwd_reg ? newer_fwd_data_reg : newer_q;

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            s1_drain_reg       <= drn_go;
            s1_pix_reg         <= req.pixel_in;
            s1_addr_reg        <= pix_go ? col_reg : drain_reg;
            s1_first_reg       <= pix_go ? (col_reg == '0) : (drain_reg == '0);
            s1_second_reg      <= (col_reg == AW'(1));
            s1_last_reg        <= pix_go ? (col_reg == wlast) : (drain_reg == wlast);
            s1_row0_reg        <= (row_reg == '0);
            s1_row1_reg        <= (row_reg == RB'(1));
            older_fwd_reg      <= older_we && (s1_addr_reg == rd_addr);
            older_fwd_data_reg <= newer_rd;
            newer_fwd_reg      <= newer_we && (s1_addr_reg == rd_addr);
            newer_fwd_data_reg <= s1_pix_reg;
        end
    end

    // column sums and window
    always_comb
    begin
        top_px   = s1_row1_reg ? s1_pix_reg : older_rd;
        cs_pix   = CSB'(top_px) + CSB'(newer_rd) + CSB'(s1_pix_reg);
        cs_drn   = {1'b0, older_rd, 1'b0} + CSB'(newer_rd);
        cs_first = {1'b0, newer_rd, 1'b0} + CSB'(s1_pix_reg);
        left_cs  = win_left_reg;
        right_cs = cs_drn;

        win_left_next = win_left_reg;
        win_mid_next  = win_mid_reg;
        cs0_next      = cs0_reg;
        s2_n_next     = 2'd0;
        s2_res0_next  = s2_res0_reg;
        s2_res1_next  = s2_res1_reg;

        if (s1_valid_reg)
        begin
            if (s1_drain_reg)
            begin
                s2_n_next                = 2'd1;
                s2_res0_next.last_of_run = 1'b1;
                s2_res0_next.row_end     = s1_last_reg;
                s2_res0_next.frame_end   = s1_last_reg;
                if (s1_first_reg)
                begin
                    // left neighbor of column zero mirrors to column one
                    s2_res0_next.sum = SB'(cs_drn) + SB'(cs0_reg) + SB'(cs_drn);
                    win_left_next    = cs0_reg;
                end
                else
                begin
                    right_cs         = s1_last_reg ? win_left_reg : cs_drn;
                    s2_res0_next.sum = SB'(win_left_reg) + SB'(win_mid_reg) + SB'(right_cs);
                    win_left_next    = win_mid_reg;
                end
                win_mid_next = cs_drn;
            end
            else if (!s1_row0_reg)
            begin
                if (s1_first_reg)
                begin
                    cs0_next = cs_first;
                end
                else
                begin
                    left_cs                  = s1_second_reg ? cs_pix : win_left_reg;
                    s2_n_next                = s1_last_reg ? 2'd2 : 2'd1;
                    s2_res0_next.sum         = SB'(left_cs) + SB'(win_mid_reg) + SB'(cs_pix);
                    s2_res0_next.last_of_run = !s1_last_reg;
                    s2_res0_next.row_end     = 1'b0;
                    s2_res0_next.frame_end   = 1'b0;
                    // right neighbor of the last column mirrors to its left
                    s2_res1_next.sum         = SB'(win_mid_reg) + SB'(cs_pix) + SB'(win_mid_reg);
                    s2_res1_next.last_of_run = 1'b1;
                    s2_res1_next.row_end     = 1'b1;
                    s2_res1_next.frame_end   = 1'b0;
                end
                win_left_next = win_mid_reg;
                win_mid_next  = cs_pix;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_left_reg <= win_left_next;
        win_mid_reg  <= win_mid_next;
        cs0_reg      <= cs0_next;
        s2_res0_reg  <= s2_res0_next;
        s2_res1_reg  <= s2_res1_next;
    end

    // divide by nine and hand to the queue
    always_comb
    begin
        push.count          = s2_n_reg;
        push.r0.pixel_out   = bxf_pkg::div9(s2_res0_reg.sum);
        push.r0.last_of_run = s2_res0_reg.last_of_run;
        push.r0.row_end     = s2_res0_reg.row_end;
        push.r0.frame_end   = s2_res0_reg.frame_end;
        push.r1.pixel_out   = bxf_pkg::div9(s2_res1_reg.sum);
        push.r1.last_of_run = s2_res1_reg.last_of_run;
        push.r1.row_end     = s2_res1_reg.row_end;
        push.r1.frame_end   = s2_res1_reg.frame_end;
    end

    bxf_out_queue u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .level (q_level),
        .rsp   (rsp)
    );

    `BXF_ASSERT(a_drain_at_origin, clk, rst_n, draining_reg |-> (col_reg == '0 && row_reg == '0))
    `BXF_ASSERT(a_drain_idle, clk, rst_n, !draining_reg |-> (drain_reg == '0))
    `BXF_ASSERT_NEVER(a_pix_same_addr, clk, rst_n, pix_go && s1_valid_reg && !s1_drain_reg && (s1_addr_reg == rd_addr))

endmodule

`default_nettype wire

[rtl/bxf_ram.sv]
// generic single-port-write ram with registered read
`default_nettype none

module bxf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/bxf_out_queue.sv]
// result queue that takes up to two items a cycle and feeds the output channel
`default_nettype none

`include "assert_macros.svh"

module bxf_out_queue (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire bxf_pkg::push_t                    push,
    output logic [bxf_pkg::QUEUE_PTR_BITS:0]       level,
    bxf_rsp_if.source                              rsp
);

    localparam int QPB = bxf_pkg::QUEUE_PTR_BITS;

    bxf_pkg::result_t entries_reg [bxf_pkg::QUEUE_DEPTH];
    logic [QPB-1:0]   wr_ptr_reg;
    logic [QPB-1:0]   wr_ptr_next;
    logic [QPB-1:0]   rd_ptr_reg;
    logic [QPB-1:0]   rd_ptr_next;
    logic [QPB:0]     count_reg;
    logic [QPB:0]     count_next;
    logic             pop;
    bxf_pkg::result_t head;

    assign head            = entries_reg[rd_ptr_reg];
    assign rsp.valid       = (count_reg != '0);
    assign rsp.pixel_out   = head.pixel_out;
    assign rsp.last_of_run = head.last_of_run;
    assign rsp.row_end     = head.row_end;
    assign rsp.frame_end   = head.frame_end;
    assign pop             = rsp.valid && rsp.ready;
    assign level           = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPB'(push.count);
        rd_ptr_next = rd_ptr_reg + QPB'(pop);
        count_next  = count_reg + (QPB+1)'(push.count) - (QPB+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.count == 2'd2)
        begin
            entries_reg[QPB'(wr_ptr_reg + QPB'(1))] <= push.r1;
        end
    end

    `BXF_ASSERT(a_no_overflow, clk, rst_n, ((QPB+2)'(count_reg) + (QPB+2)'(push.count)) <= (QPB+2)'(bxf_pkg::QUEUE_DEPTH))
    `BXF_ASSERT(a_ptr_gap, clk, rst_n, QPB'(wr_ptr_reg - rd_ptr_reg) == count_reg[QPB-1:0])
    `BXF_ASSERT(a_level_range, clk, rst_n, count_reg <= (QPB+1)'(bxf_pkg::QUEUE_DEPTH))

endmodule

`default_nettype wire

[test/tb_box_filter_3x3_reflect_core.sv]
// self-checking testbench of the 3x3 reflected box filter core
`timescale 1ns / 1ps

module tb_box_filter_3x3_reflect_core;

    localparam int PIXEL_BITS     = bxf_pkg::PIXEL_BITS;
    localparam int CFG_BITS       = bxf_pkg::CFG_BITS;
    localparam int CFG_INDEX_BITS = bxf_pkg::CFG_INDEX_BITS;

    localparam int MAX_WIDTH    = 1024;
    localparam int SIZE_LIMIT   = 1024;
    localparam int RANDOM_ITEMS = 560;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD    = 400;
    localparam int EXTREME_CUT  = 100;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    bxf_req_if req_ch ();
    bxf_rsp_if rsp_ch ();

    box_filter_3x3_reflect_core #(
        .MAX_WIDTH(MAX_WIDTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req(req_ch),
        .rsp(rsp_ch)
    );

    // filter state as the block should hold it
    logic [CFG_BITS-1:0] width_reg;
    logic [CFG_BITS-1:0] height_reg;
    logic [PIXEL_BITS-1:0] older_row [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] newer_row [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] window_col [6];
    logic [9:0] row_idx;
    logic [9:0] col_idx;
    logic [9:0] drain_idx;
    bit draining;

    bxf_pkg::result_t expected_pixels[$];
    int error_count;
    int useful_items;
    int burst_left;
    bit steady_sender;
    int hold_request;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clamp_size(input logic [CFG_BITS-1:0] v, input int hi);
        if (v < 2)
            return 2;
        if (v > hi)
            return hi;
        return int'(v);
    endfunction

    function automatic bxf_pkg::result_t make_result(input int sum, input logic last,
                                                     input logic rend, input logic fend);
        bxf_pkg::result_t r;
        r.pixel_out   = PIXEL_BITS'(sum / 9);
        r.last_of_run = last;
        r.row_end     = rend;
        r.frame_end   = fend;
        return r;
    endfunction

    function automatic void restart_frame();
        row_idx   = '0;
        col_idx   = '0;
        drain_idx = '0;
        draining  = 1'b0;
    endfunction

    function automatic void filter_pixel(input logic [PIXEL_BITS-1:0] px);
        int w, h, c, r;
        int cur, mid, left;
        logic [PIXEL_BITS-1:0] top;
        logic [PIXEL_BITS-1:0] above;
        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, SIZE_LIMIT);
        c = int'(col_idx);
        r = int'(row_idx);
        if (c >= w)
            c = w - 1;
        if (r == 0)
        begin
            newer_row[c] = px;
        end
        else
        begin
            top   = (r == 1) ? px : older_row[c];
            above = newer_row[c];
            cur   = int'(top) + int'(above) + int'(px);
            mid   = int'(window_col[0]) + int'(window_col[1]) + int'(window_col[2]);
            if (c == 1)
                left = cur;
            else
                left = int'(window_col[3]) + int'(window_col[4]) + int'(window_col[5]);
            if (c >= 1)
            begin
                expected_pixels.push_back(make_result(left + mid + cur, c != w - 1, 1'b0, 1'b0));
                if (c == w - 1)
                    expected_pixels.push_back(make_result(2 * mid + cur, 1'b1, 1'b1, 1'b0));
            end
            window_col[3] = window_col[0];
            window_col[4] = window_col[1];
            window_col[5] = window_col[2];
            window_col[0] = top;
            window_col[1] = above;
            window_col[2] = px;
            older_row[c] = above;
            newer_row[c] = px;
        end
        if (c + 1 >= w)
        begin
            col_idx = '0;
            if (r + 1 >= h)
            begin
                row_idx  = '0;
                draining = 1'b1;
            end
            else
                row_idx = 10'(r + 1);
        end
        else
            col_idx = 10'(c + 1);
    endfunction

    function automatic void filter_drain();
        int w, d, lf, rt, sum;
        logic last;
        w = clamp_size(width_reg, MAX_WIDTH);
        d = int'(drain_idx);
        if (d >= w)
            d = w - 1;
        lf = (d == 0) ? 1 : d - 1;
        rt = (d + 1 >= w) ? w - 2 : d + 1;
        sum = 2 * int'(older_row[lf]) + int'(newer_row[lf])
            + 2 * int'(older_row[d]) + int'(newer_row[d])
            + 2 * int'(older_row[rt]) + int'(newer_row[rt]);
        last = (d == w - 1);
        expected_pixels.push_back(make_result(sum, 1'b1, last, last));
        if (last)
            restart_frame();
        else
            drain_idx = 10'(d + 1);
    endfunction

    function automatic logic [PIXEL_BITS-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return PIXEL_BITS'($urandom());
        endcase
    endfunction

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_BITS-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == bxf_pkg::REG_IMAGE_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        restart_frame();
        @(posedge clk);
    endtask

    task automatic send_item(input logic rt, input logic [PIXEL_BITS-1:0] px);
        int gap;
        if (burst_left == 0 && !steady_sender)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= rt;
        req_ch.pixel_in <= px;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (rt == REQ_PIXEL)
        begin
            if (!draining)
                filter_pixel(px);
        end
        else if (draining)
            filter_drain();
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one frame with stray items mixed in; cut >= 0 stops early at that position
    task automatic stream_frame(input int cols, input int rows, input int cut);
        int k, total;
        total = cols * rows;
        for (k = 0; k < total + cols; k++)
        begin
            if (k == cut)
                return;
            if (k < total)
            begin
                if ($urandom_range(0, 15) == 0)
                    send_item(REQ_DRAIN, PIXEL_BITS'($urandom()));
                send_item(REQ_PIXEL, pick_pixel());
            end
            else
            begin
                if ($urandom_range(0, 7) == 0)
                    send_item(REQ_PIXEL, PIXEL_BITS'($urandom()));
                send_item(REQ_DRAIN, PIXEL_BITS'($urandom()));
            end
            useful_items++;
        end
    endtask

    task automatic test_reset_defaults();
        send_item(REQ_PIXEL, 8'h00);
        send_item(REQ_PIXEL, 8'hFF);
        send_item(REQ_DRAIN, 8'hA5);
        send_item(REQ_PIXEL, 8'h5A);
        wait_idle();
    endtask

    task automatic test_smallest_frame();
        write_register(bxf_pkg::REG_IMAGE_WIDTH, 11'd2);
        write_register(bxf_pkg::REG_IMAGE_HEIGHT, 11'd2);
        send_item(REQ_PIXEL, 8'hFF);
        send_item(REQ_PIXEL, 8'h00);
        send_item(REQ_PIXEL, 8'h00);
        send_item(REQ_PIXEL, 8'hFF);
        send_item(REQ_PIXEL, 8'hFF);
        send_item(REQ_DRAIN, 8'h00);
        send_item(REQ_DRAIN, 8'hFF);
        wait_idle();
    endtask

    task automatic test_size_clamping();
        write_register(bxf_pkg::REG_IMAGE_WIDTH, 11'd1);
        write_register(bxf_pkg::REG_IMAGE_HEIGHT, 11'd0);
        repeat (4) send_item(REQ_PIXEL, 8'hFF);
        repeat (2) send_item(REQ_DRAIN, 8'h00);
        wait_idle();
    endtask

    task automatic test_border_pattern();
        int k;
        write_register(bxf_pkg::REG_IMAGE_WIDTH, 11'd3);
        write_register(bxf_pkg::REG_IMAGE_HEIGHT, 11'd3);
        for (k = 0; k < 9; k++)
            send_item(REQ_PIXEL, (((k / 3) + (k % 3)) % 2 == 1) ? 8'hFF : 8'h00);
        repeat (3) send_item(REQ_DRAIN, 8'h00);
        wait_idle();
    endtask

    task automatic test_random_frames();
        int cols, rows, cut;
        bit restart_due;
        restart_due = 1'b1;
        while (useful_items < RANDOM_ITEMS)
        begin
            wait_idle();
            case ($urandom_range(0, 3))
                0:
                begin
                    if (restart_due)
                        write_register(bxf_pkg::REG_IMAGE_WIDTH,
                                       CFG_BITS'($urandom_range(0, 9)));
                end
                1: write_register(bxf_pkg::REG_IMAGE_WIDTH, CFG_BITS'($urandom_range(0, 9)));
                2: write_register(bxf_pkg::REG_IMAGE_HEIGHT, CFG_BITS'($urandom_range(0, 7)));
                default:
                begin
                    write_register(bxf_pkg::REG_IMAGE_WIDTH, ($urandom_range(0, 19) == 0)
                                   ? CFG_BITS'($urandom_range(11, 40))
                                   : CFG_BITS'($urandom_range(0, 9)));
                    write_register(bxf_pkg::REG_IMAGE_HEIGHT, CFG_BITS'($urandom_range(0, 7)));
                end
            endcase
            cols = clamp_size(width_reg, MAX_WIDTH);
            rows = clamp_size(height_reg, SIZE_LIMIT);
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cols * rows + cols - 1) : -1;
            restart_due = (cut >= 0);
            stream_frame(cols, rows, cut);
        end
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        write_register(bxf_pkg::REG_IMAGE_WIDTH, 11'd16);
        write_register(bxf_pkg::REG_IMAGE_HEIGHT, 11'd4);
        steady_sender = 1'b1;
        hold_request = LONG_HOLD;
        stream_frame(16, 4, -1);
        steady_sender = 1'b0;
        wait_idle();
    endtask

    // oversized and undersized registers, with the frames cut short
    task automatic test_extreme_sizes();
        write_register(bxf_pkg::REG_IMAGE_WIDTH, 11'd2047);
        write_register(bxf_pkg::REG_IMAGE_HEIGHT, 11'd2);
        stream_frame(1024, 2, EXTREME_CUT);
        wait_idle();
        write_register(bxf_pkg::REG_IMAGE_WIDTH, 11'd0);
        write_register(bxf_pkg::REG_IMAGE_HEIGHT, 11'd2047);
        stream_frame(2, 1024, EXTREME_CUT);
        wait_idle();
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cfg_write       <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_PIXEL;
        req_ch.pixel_in <= '0;
        error_count   = 0;
        useful_items  = 0;
        burst_left    = 0;
        steady_sender = 1'b0;
        hold_request  = 0;
        width_reg  = bxf_pkg::RESET_SIZE;
        height_reg = bxf_pkg::RESET_SIZE;
        foreach (window_col[i])
            window_col[i] = '0;
        restart_frame();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_smallest_frame();
        test_size_clamping();
        test_border_pattern();
        test_random_frames();
        test_output_backpressure();
        test_extreme_sizes();

        wait_idle();
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // result side pacing: random phases of stalling plus a long hold when a test asks for one
    initial
    begin : rsp_pacing
        int hold_left;
        int phase_left;
        int ready_pct;
        hold_left  = 0;
        phase_left = 0;
        ready_pct  = 100;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    phase_left = $urandom_range(5, 60);
                    case ($urandom_range(0, 3))
                        0: ready_pct = 100;
                        1: ready_pct = 70;
                        2: ready_pct = 40;
                        default: ready_pct = 10;
                    endcase
                end
                phase_left--;
                rsp_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    task automatic report_field(input string field, input int want, input int got);
        error_count++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    initial
    begin : result_check
        bxf_pkg::result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected item, expected none, actual pixel_out %0d",
                             $time, rsp_ch.pixel_out);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (rsp_ch.pixel_out !== want.pixel_out)
                        report_field("pixel_out", want.pixel_out, rsp_ch.pixel_out);
                    if (rsp_ch.last_of_run !== want.last_of_run)
                        report_field("last_of_run", want.last_of_run, rsp_ch.last_of_run);
                    if (rsp_ch.row_end !== want.row_end)
                        report_field("row_end", want.row_end, rsp_ch.row_end);
                    if (rsp_ch.frame_end !== want.frame_end)
                        report_field("frame_end", want.frame_end, rsp_ch.frame_end);
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/bxf_pkg.sv
rtl/bxf_req_if.sv
rtl/bxf_rsp_if.sv
rtl/bxf_ram.sv
rtl/bxf_out_queue.sv
rtl/box_filter_3x3_reflect_core.sv
test/tb_box_filter_3x3_reflect_core.sv
